// ===== hdl/mono_framebuffer_span_engine_top_assert.svh =====
// Assertion macros shared by the span engine.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef MONO_FRAMEBUFFER_SPAN_ENGINE_TOP_ASSERT_SVH
`define MONO_FRAMEBUFFER_SPAN_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBSE_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBSE_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fbse_pkg.sv =====
package fbse_pkg;

	// Screen geometry and store size.
	localparam int SCREEN_WIDTH  = 84;
	localparam int SCREEN_HEIGHT = 48;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int XW            = 7;
	localparam int YW            = 6;
	localparam int PAGE_W        = YW - 3;

	localparam logic [XW-1:0]     X_LIMIT    = XW'(SCREEN_WIDTH);
	localparam logic [YW-1:0]     Y_LIMIT    = YW'(SCREEN_HEIGHT);
	localparam logic [ADDR_W-1:0] ADDR_LIMIT = ADDR_W'(STORE_BYTES);
	localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(STORE_BYTES - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(SCREEN_WIDTH);
	localparam logic [7:0]        FILL_HATCH = 8'hAA;

	// Command codes.
	localparam logic [2:0] ACT_PLOT  = 3'd0;
	localparam logic [2:0] ACT_HSPAN = 3'd1;
	localparam logic [2:0] ACT_VSPAN = 3'd2;
	localparam logic [2:0] ACT_FILL  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	// Colour codes.
	localparam logic [2:0] COL_WHITE  = 3'd0;
	localparam logic [2:0] COL_BLACK  = 3'd1;
	localparam logic [2:0] COL_INVERT = 3'd2;
	localparam logic [2:0] COL_HATCH1 = 3'd3;
	localparam logic [2:0] COL_HATCH2 = 3'd4;
	localparam logic [2:0] COL_HATCH3 = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_HATCH1_ODD  = 3'd0;
	localparam logic [2:0] REG_HATCH1_EVEN = 3'd1;
	localparam logic [2:0] REG_HATCH2_ODD  = 3'd2;
	localparam logic [2:0] REG_HATCH2_EVEN = 3'd3;
	localparam logic [2:0] REG_HATCH3_ODD  = 3'd4;
	localparam logic [2:0] REG_HATCH3_EVEN = 3'd5;

	// Byte operation applied to each store byte.
	typedef enum logic [2:0] {
		OP_SET,
		OP_CLR,
		OP_XOR,
		OP_PAT,
		OP_HATCH,
		OP_READ
	} op_t;

	// Hatch patterns, indexed by register index.
	typedef logic [5:0][7:0] hatch_set_t;

	// Read word and write activity handed from the engine to the top level.
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       wr_active;
	} fbse_res_t;

	// Base address of a page.
	function automatic logic [ADDR_W-1:0] page_base(input logic [PAGE_W-1:0] page);
		return ADDR_W'(32'(page) * SCREEN_WIDTH);
	endfunction

endpackage

// ===== hdl/fbse_ram.sv =====
module fbse_ram #(
	parameter int DEPTH = 504,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/fbse_engine.sv =====
module fbse_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            action,
	input  logic [6:0]            x_start,
	input  logic [6:0]            x_end,
	input  logic [5:0]            y_start,
	input  logic [5:0]            y_end,
	input  logic [2:0]            color,
	input  logic [8:0]            byte_index,
	input  fbse_pkg::hatch_set_t  hatch,
	input  logic                  slot_free,
	output fbse_pkg::fbse_res_t   res
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RD    = 4'b0100,
		ST_WR    = 4'b1000
	} state_t;

	state_t state_q;

	logic [fbse_pkg::ADDR_W-1:0] addr_q;
	logic [fbse_pkg::ADDR_W-1:0] cnt_q;
	logic                        vert_q;
	logic                        first_q;
	logic                        par_q;
	fbse_pkg::op_t               op_q;
	logic [7:0]                  top_q;
	logic [7:0]                  bot_q;
	logic [7:0]                  mid_q;
	logic [7:0]                  pat_q;

	// Decoded command.
	logic                        j_go;
	fbse_pkg::op_t               j_op;
	logic [fbse_pkg::ADDR_W-1:0] j_addr;
	logic [fbse_pkg::ADDR_W-1:0] j_cnt;
	logic                        j_vert;
	logic                        j_par;
	logic [7:0]                  j_top;
	logic [7:0]                  j_bot;
	logic [7:0]                  j_mid;
	logic [7:0]                  j_pat;

	logic [6:0]    x_lo, x_hi;
	logic [5:0]    y_lo, y_hi;
	logic          xs_ok, xe_ok, ys_ok, ye_ok;
	logic [7:0]    y_bit;
	logic [7:0]    v_top, v_bot;
	logic [1:0]    h_sel;
	logic [7:0]    v_pat;
	fbse_pkg::op_t plot_op;

	logic          accept;
	logic          ram_we, ram_re;
	logic [fbse_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [7:0]    mask_cur, new_byte;
	logic          last;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Ordered ends, range checks and the shared masks.
	always_comb begin
		x_lo    = (x_start < x_end) ? x_start : x_end;
		x_hi    = (x_start < x_end) ? x_end : x_start;
		y_lo    = (y_start < y_end) ? y_start : y_end;
		y_hi    = (y_start < y_end) ? y_end : y_start;
		xs_ok   = x_start < fbse_pkg::X_LIMIT;
		xe_ok   = x_end < fbse_pkg::X_LIMIT;
		ys_ok   = y_start < fbse_pkg::Y_LIMIT;
		ye_ok   = y_end < fbse_pkg::Y_LIMIT;
		y_bit   = 8'h80 >> y_start[2:0];
		v_top   = 8'hFF >> y_lo[2:0];
		v_bot   = 8'hFF << (3'd7 - y_hi[2:0]);
		h_sel   = 2'(color - fbse_pkg::COL_HATCH1);
		v_pat   = hatch[{h_sel, ~x_start[0]}];
		if (color == fbse_pkg::COL_BLACK) begin
			plot_op = fbse_pkg::OP_SET;
		end else if (color == fbse_pkg::COL_HATCH1) begin
			plot_op = fbse_pkg::OP_HATCH;
		end else begin
			plot_op = fbse_pkg::OP_CLR;
		end
	end

	// Turn one command into a run of byte operations.
	always_comb begin
		j_go   = 1'b0;
		j_op   = fbse_pkg::OP_SET;
		j_addr = fbse_pkg::page_base(y_start[5:3]) + fbse_pkg::ADDR_W'(x_start);
		j_cnt  = '0;
		j_vert = 1'b0;
		j_par  = x_start[0] ^ y_start[0];
		j_top  = y_bit;
		j_bot  = y_bit;
		j_mid  = y_bit;
		j_pat  = 8'h00;
		case (action)
			fbse_pkg::ACT_PLOT: begin
				j_go = xs_ok && ys_ok;
				j_op = plot_op;
			end
			fbse_pkg::ACT_HSPAN: begin
				if (xs_ok && xe_ok && ys_ok) begin
					if (x_lo == x_hi) begin
						j_go = 1'b1;
						j_op = plot_op;
					end else begin
						j_addr = fbse_pkg::page_base(y_start[5:3])
							+ fbse_pkg::ADDR_W'(x_lo);
						j_cnt  = fbse_pkg::ADDR_W'(x_hi - x_lo);
						j_par  = x_lo[0] ^ y_start[0];
						j_go   = 1'b1;
						case (color)
							fbse_pkg::COL_BLACK:  j_op = fbse_pkg::OP_SET;
							fbse_pkg::COL_WHITE:  j_op = fbse_pkg::OP_CLR;
							fbse_pkg::COL_INVERT: j_op = fbse_pkg::OP_XOR;
							fbse_pkg::COL_HATCH1: j_op = fbse_pkg::OP_HATCH;
							default:              j_go = 1'b0;
						endcase
					end
				end
			end
			fbse_pkg::ACT_VSPAN: begin
				j_addr = fbse_pkg::page_base(y_lo[5:3]) + fbse_pkg::ADDR_W'(x_start);
				j_cnt  = fbse_pkg::ADDR_W'(y_hi[5:3] - y_lo[5:3]);
				j_vert = 1'b1;
				j_top  = v_top;
				j_bot  = v_bot;
				j_mid  = 8'hFF;
				j_pat  = v_pat;
				j_go   = xs_ok && ys_ok && ye_ok && (y_lo != y_hi);
				case (color)
					fbse_pkg::COL_BLACK:  j_op = fbse_pkg::OP_SET;
					fbse_pkg::COL_WHITE:  j_op = fbse_pkg::OP_CLR;
					fbse_pkg::COL_INVERT: j_op = fbse_pkg::OP_XOR;
					fbse_pkg::COL_HATCH1,
					fbse_pkg::COL_HATCH2,
					fbse_pkg::COL_HATCH3: begin
						j_op = fbse_pkg::OP_PAT;
						if (v_pat == 8'h00) begin
							j_go = 1'b0;
						end
					end
					default: j_go = 1'b0;
				endcase
			end
			fbse_pkg::ACT_FILL: begin
				j_addr = '0;
				j_cnt  = fbse_pkg::ADDR_LAST;
				j_top  = 8'hFF;
				j_bot  = 8'hFF;
				j_mid  = 8'hFF;
				j_pat  = fbse_pkg::FILL_HATCH;
				j_go   = 1'b1;
				case (color)
					fbse_pkg::COL_BLACK:  j_op = fbse_pkg::OP_SET;
					fbse_pkg::COL_WHITE:  j_op = fbse_pkg::OP_CLR;
					fbse_pkg::COL_INVERT: j_op = fbse_pkg::OP_XOR;
					fbse_pkg::COL_HATCH1: j_op = fbse_pkg::OP_PAT;
					default:              j_go = 1'b0;
				endcase
			end
			fbse_pkg::ACT_READ: begin
				j_addr = byte_index;
				j_op   = fbse_pkg::OP_READ;
				j_go   = byte_index < fbse_pkg::ADDR_LIMIT;
			end
			default: j_go = 1'b0;
		endcase
	end

	// Mask of the current byte and its modified value.
	always_comb begin
		last = (cnt_q == '0);
		if (first_q && last) begin
			mask_cur = top_q & bot_q;
		end else if (first_q) begin
			mask_cur = top_q;
		end else if (last) begin
			mask_cur = bot_q;
		end else begin
			mask_cur = mid_q;
		end
		case (op_q)
			fbse_pkg::OP_SET:   new_byte = ram_rdata | mask_cur;
			fbse_pkg::OP_CLR:   new_byte = ram_rdata & ~mask_cur;
			fbse_pkg::OP_XOR:   new_byte = ram_rdata ^ mask_cur;
			fbse_pkg::OP_PAT:   new_byte = (ram_rdata & ~mask_cur) | (pat_q & mask_cur);
			fbse_pkg::OP_HATCH: new_byte = par_q ? (ram_rdata | mask_cur)
				: (ram_rdata & ~mask_cur);
			default:            new_byte = ram_rdata;
		endcase
	end

	// Memory port control: clearing pass, then read followed by write-back.
	always_comb begin
		ram_re    = (state_q == ST_RD);
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = new_byte;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_wdata = 8'h00;
		end else if (state_q == ST_WR && op_q != fbse_pkg::OP_READ) begin
			ram_we = 1'b1;
		end
	end

	assign res.load      = (state_q == ST_WR) && (op_q == fbse_pkg::OP_READ) && slot_free;
	assign res.data      = ram_rdata;
	assign res.wr_active = ram_we;

	fbse_ram #(
		.DEPTH(fbse_pkg::STORE_BYTES),
		.WIDTH(8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// Sequencer state and byte address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + fbse_pkg::ADDR_W'(1);
					if (addr_q == fbse_pkg::ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && j_go) begin
						addr_q  <= j_addr;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (op_q == fbse_pkg::OP_READ) begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end else if (last) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q  <= addr_q + (vert_q ? fbse_pkg::ROW_STEP
							: fbse_pkg::ADDR_W'(1));
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command payload and per-byte progress.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_q    <= j_op;
			cnt_q   <= j_cnt;
			vert_q  <= j_vert;
			first_q <= 1'b1;
			par_q   <= j_par;
			top_q   <= j_top;
			bot_q   <= j_bot;
			mid_q   <= j_mid;
			pat_q   <= j_pat;
		end else if (state_q == ST_WR && op_q != fbse_pkg::OP_READ && !last) begin
			cnt_q   <= cnt_q - fbse_pkg::ADDR_W'(1);
			first_q <= 1'b0;
			par_q   <= ~par_q;
		end
	end

endmodule

// ===== hdl/mono_framebuffer_span_engine_top.sv =====
// A read command's word is read from the store and then loaded into the output register;
// it is held back while an earlier word still waits at the output.
// Each byte is read and then written back through the single store memory, so a new
// command is taken only after the last byte of the current one is written back.
// A vertical span touches up to 6 bytes, one per page, and a fill all 504 store bytes.
// Reset clears the control logic, reloads the hatch registers, and then a clearing
// pass zeroes all 504 store bytes before the first command is taken.
module mono_framebuffer_span_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] action,
	input  logic [6:0] x_start,
	input  logic [6:0] x_end,
	input  logic [5:0] y_start,
	input  logic [5:0] y_end,
	input  logic [2:0] color,
	input  logic [8:0] byte_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	fbse_pkg::hatch_set_t hatch_q;
	fbse_pkg::fbse_res_t  res;
	logic                 out_valid_q;
	logic [7:0]           read_data_q;
	logic                 slot_free;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// Hatch pattern registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hatch_q[fbse_pkg::REG_HATCH1_ODD]  <= 8'hAA;
			hatch_q[fbse_pkg::REG_HATCH1_EVEN] <= 8'h55;
			hatch_q[fbse_pkg::REG_HATCH2_ODD]  <= 8'h88;
			hatch_q[fbse_pkg::REG_HATCH2_EVEN] <= 8'h22;
			hatch_q[fbse_pkg::REG_HATCH3_ODD]  <= 8'h44;
			hatch_q[fbse_pkg::REG_HATCH3_EVEN] <= 8'h11;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbse_pkg::REG_HATCH1_ODD:  hatch_q[fbse_pkg::REG_HATCH1_ODD]  <= cfg_data;
				fbse_pkg::REG_HATCH1_EVEN: hatch_q[fbse_pkg::REG_HATCH1_EVEN] <= cfg_data;
				fbse_pkg::REG_HATCH2_ODD:  hatch_q[fbse_pkg::REG_HATCH2_ODD]  <= cfg_data;
				fbse_pkg::REG_HATCH2_EVEN: hatch_q[fbse_pkg::REG_HATCH2_EVEN] <= cfg_data;
				fbse_pkg::REG_HATCH3_ODD:  hatch_q[fbse_pkg::REG_HATCH3_ODD]  <= cfg_data;
				fbse_pkg::REG_HATCH3_EVEN: hatch_q[fbse_pkg::REG_HATCH3_EVEN] <= cfg_data;
				default: ;
			endcase
		end
	end

	fbse_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.x_start    (x_start),
		.x_end      (x_end),
		.y_start    (y_start),
		.y_end      (y_end),
		.color      (color),
		.byte_index (byte_index),
		.hatch      (hatch_q),
		.slot_free  (slot_free),
		.res        (res)
	);

	// Output register holding the read word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			read_data_q <= res.data;
		end
	end

	`include "mono_framebuffer_span_engine_top_assert.svh"

	`FBSE_CHECK_NEXT(a_word_held, out_valid && !out_ready, out_valid && $stable(read_data), "read word not held")
	`FBSE_CHECK_NOW(a_no_write_when_ready, res.wr_active, !in_ready, "store written while commands are taken")
	`FBSE_CHECK_NOW(a_no_overwrite, res.load, !out_valid_q || out_ready, "pending read word overwritten")

endmodule

// ===== tb/sv/tb_mono_framebuffer_span_engine_top.sv =====
module tb_mono_framebuffer_span_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fbse_pkg::*;

	// One drawing or read command as it crosses the input channel.
	typedef struct {
		logic [2:0] action;
		logic [6:0] xs;
		logic [6:0] xe;
		logic [5:0] ys;
		logic [5:0] ye;
		logic [2:0] color;
		logic [8:0] bidx;
	} span_cmd_t;

	// Shadow framebuffer and hatch registers, with the read words still owed by the block.
	class frame_scoreboard;
		logic [7:0] frame [STORE_BYTES];
		logic [7:0] hatch [6];
		logic [7:0] read_words [$];
		int errors;

		function new();
			foreach (frame[i]) frame[i] = '0;
			hatch = '{8'hAA, 8'h55, 8'h88, 8'h22, 8'h44, 8'h11};
			errors = 0;
		endfunction

		function void set_hatch(logic [2:0] idx, logic [7:0] val);
			if (idx <= REG_HATCH3_EVEN) hatch[idx] = val;
		endfunction

		function void plot_px(int x, int y, logic [2:0] c);
			int a;
			logic [7:0] m;
			a = (y >> 3) * SCREEN_WIDTH + x;
			m = 8'h80 >> (y & 7);
			if (c == COL_BLACK || (c == COL_HATCH1 && ((x + y) & 1))) frame[a] |= m;
			else frame[a] &= ~m;
		endfunction

		function void span_row(int y, int xa, int xb, logic [2:0] c);
			int lo, hi, a;
			logic [7:0] m;
			lo = (xa < xb) ? xa : xb;
			hi = (xa < xb) ? xb : xa;
			m = 8'h80 >> (y & 7);
			if (lo == hi) begin
				plot_px(lo, y, c);
				return;
			end
			for (int x = lo; x <= hi; x++) begin
				a = (y >> 3) * SCREEN_WIDTH + x;
				case (c)
					COL_BLACK: frame[a] |= m;
					COL_WHITE: frame[a] &= ~m;
					COL_INVERT: frame[a] ^= m;
					COL_HATCH1: begin
						if ((x + y) & 1) frame[a] |= m;
						else frame[a] &= ~m;
					end
					default: ;
				endcase
			end
		endfunction

		function void mask_byte(int a, logic [7:0] m, logic [2:0] c, logic [7:0] pat);
			case (c)
				COL_BLACK: frame[a] |= m;
				COL_WHITE: frame[a] &= ~m;
				COL_INVERT: frame[a] ^= m;
				default: frame[a] = (frame[a] & ~m) | (pat & m);
			endcase
		endfunction

		function void span_column(int x, int ya, int yb, logic [2:0] c);
			int lo, hi, p0, p1;
			logic [7:0] pat, top, bottom;
			lo = (ya < yb) ? ya : yb;
			hi = (ya < yb) ? yb : ya;
			if (lo == hi) return;
			pat = '0;
			// Hatch colours pick the odd or even column pattern; an empty pattern draws nothing.
			if (c >= COL_HATCH1) begin
				if (c > COL_HATCH3) return;
				pat = hatch[(int'(c) - int'(COL_HATCH1)) * 2 + ((x & 1) ? 0 : 1)];
				if (pat == 0) return;
			end
			top = 8'hFF >> (lo & 7);
			bottom = 8'hFF << (7 - (hi & 7));
			p0 = lo >> 3;
			p1 = hi >> 3;
			// Both ends in one byte: the masks are merged so an invert lands only once.
			if (p0 == p1) begin
				mask_byte(p0 * SCREEN_WIDTH + x, top & bottom, c, pat);
				return;
			end
			mask_byte(p0 * SCREEN_WIDTH + x, top, c, pat);
			for (int p = p0 + 1; p < p1; p++) mask_byte(p * SCREEN_WIDTH + x, 8'hFF, c, pat);
			mask_byte(p1 * SCREEN_WIDTH + x, bottom, c, pat);
		endfunction

		function void fill_frame(logic [2:0] c);
			foreach (frame[i]) begin
				case (c)
					COL_BLACK: frame[i] = 8'hFF;
					COL_WHITE: frame[i] = 8'h00;
					COL_HATCH1: frame[i] = FILL_HATCH;
					COL_INVERT: frame[i] = ~frame[i];
					default: ;
				endcase
			end
		endfunction

		// Applies an accepted command to the shadow buffer and queues any read word it owes.
		function void note_command(span_cmd_t t);
			case (t.action)
				ACT_PLOT: begin
					if (t.xs < SCREEN_WIDTH && t.ys < SCREEN_HEIGHT) plot_px(t.xs, t.ys, t.color);
				end
				ACT_HSPAN: begin
					if (t.xs < SCREEN_WIDTH && t.xe < SCREEN_WIDTH && t.ys < SCREEN_HEIGHT)
						span_row(t.ys, t.xs, t.xe, t.color);
				end
				ACT_VSPAN: begin
					if (t.xs < SCREEN_WIDTH && t.ys < SCREEN_HEIGHT && t.ye < SCREEN_HEIGHT)
						span_column(t.xs, t.ys, t.ye, t.color);
				end
				ACT_FILL: fill_frame(t.color);
				ACT_READ: begin
					if (t.bidx < STORE_BYTES) read_words.push_back(frame[t.bidx]);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		task check_read(logic [7:0] got);
			logic [7:0] want;
			if (read_words.size() == 0) begin
				report_mismatch($sformatf("read word 0x%h arrived with none owed", got));
			end else begin
				want = read_words.pop_front();
				if (got !== want)
					report_mismatch($sformatf("read_data 0x%h, predicted 0x%h", got, want));
			end
		endtask

		task check_drained();
			if (read_words.size() != 0)
				report_mismatch($sformatf("%0d read words never arrived", read_words.size()));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] action;
	logic [6:0] x_start;
	logic [6:0] x_end;
	logic [5:0] y_start;
	logic [5:0] y_end;
	logic [2:0] color;
	logic [8:0] byte_index;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	frame_scoreboard sb;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int last_x = 0;

	mono_framebuffer_span_engine_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off counted down here.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Every read word taken at a rising edge is checked against the oldest one owed.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) sb.check_read(read_data);
		end
	end

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic span_cmd_t make_cmd(logic [2:0] act, int xs, int xe, int ys, int ye,
			logic [2:0] c, int bi);
		span_cmd_t t;
		t.action = act;
		t.xs = 7'(xs);
		t.xe = 7'(xe);
		t.ys = 6'(ys);
		t.ye = 6'(ye);
		t.color = c;
		t.bidx = 9'(bi);
		return t;
	endfunction

	// Mostly well-formed commands, most row spans short, some reads aimed at the last column drawn,
	// and a little noise across the full field widths.
	function automatic span_cmd_t random_command();
		span_cmd_t t;
		int r, lo, hi;
		t.action = 3'($urandom);
		t.xs = 7'($urandom);
		t.xe = 7'($urandom);
		t.ys = 6'($urandom);
		t.ye = 6'($urandom);
		t.color = 3'($urandom);
		t.bidx = 9'($urandom);
		r = $urandom_range(99);
		if (r < 4) return t;
		t.xs = 7'($urandom_range(SCREEN_WIDTH - 1));
		t.xe = 7'($urandom_range(SCREEN_WIDTH - 1));
		t.ys = 6'($urandom_range(SCREEN_HEIGHT - 1));
		t.ye = 6'($urandom_range(SCREEN_HEIGHT - 1));
		if ($urandom_range(9) != 0) t.color = 3'($urandom_range(COL_HATCH3));
		if (r < 30) begin
			t.action = ACT_READ;
			if ($urandom_range(1))
				t.bidx = 9'($urandom_range(PAGE_COUNT - 1) * SCREEN_WIDTH + last_x);
			else
				t.bidx = 9'($urandom_range(STORE_BYTES - 1));
		end else if (r < 45) begin
			t.action = ACT_PLOT;
		end else if (r < 68) begin
			t.action = ACT_HSPAN;
			if ($urandom_range(3) != 0) begin
				lo = (t.xs < 8) ? 0 : t.xs - 8;
				hi = (t.xs + 8 > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : t.xs + 8;
				t.xe = 7'($urandom_range(hi, lo));
			end
		end else if (r < 95) begin
			t.action = ACT_VSPAN;
		end else begin
			t.action = ACT_FILL;
		end
		if (t.action != ACT_READ && t.action != ACT_FILL) last_x = t.xs;
		return t;
	endfunction

	// Offers one command word, after random idle cycles, and holds it until it is taken.
	task automatic send_command(span_cmd_t t);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = t.action;
		x_start = t.xs;
		x_end = t.xe;
		y_start = t.ys;
		y_end = t.ye;
		color = t.color;
		byte_index = t.bidx;
		do @(posedge clk); while (!in_ready);
		sb.note_command(t);
		@(negedge clk);
	endtask

	task automatic write_hatch(logic [2:0] idx, logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_hatch(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Waits for every owed read word, then long enough for a fill still in progress.
	task automatic settle_engine();
		int waited;
		waited = 0;
		while (sb.read_words.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (1100) @(negedge clk);
	endtask

	initial begin
		logic [7:0] val;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		x_start = '0;
		x_end = '0;
		y_start = '0;
		y_end = '0;
		color = '0;
		byte_index = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			if (ph != 0) begin
				in_valid = 1'b0;
				settle_engine();
			end
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				default: begin send_idle = 10; recv_stall = 10; end
			endcase

			// Hatch patterns for this phase, the all-clear and all-set extremes among them.
			for (int r = REG_HATCH1_ODD; r <= REG_HATCH3_EVEN; r++) begin
				case (ph)
					0: val = (r == REG_HATCH1_ODD) ? 8'hFF :
						(r == REG_HATCH1_EVEN) ? 8'h00 : 8'($urandom);
					1: val = 8'h00;
					2: val = 8'hFF;
					default: val = 8'($urandom);
				endcase
				write_hatch(3'(r), val);
			end

			if (ph == 0) begin
				// Corners, reads at both ends of the store and past it.
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 0));
				send_command(make_cmd(ACT_PLOT, 0, 0, 0, 0, COL_BLACK, 0));
				send_command(make_cmd(ACT_PLOT, SCREEN_WIDTH - 1, 0, SCREEN_HEIGHT - 1, 0,
					COL_BLACK, 0));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 0));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, STORE_BYTES - 1));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 511));
				// Hatch plot, a plot with the invert colour (which clears the pixel), and a plot off the screen.
				send_command(make_cmd(ACT_PLOT, 1, 0, 0, 0, COL_HATCH1, 0));
				send_command(make_cmd(ACT_PLOT, 0, 0, 0, 0, COL_INVERT, 0));
				send_command(make_cmd(ACT_PLOT, 127, 0, 63, 0, COL_BLACK, 0));
				// Reversed row span, a single-pixel span, a colour that draws nothing, and a reversed full-width hatch span.
				send_command(make_cmd(ACT_HSPAN, 10, 2, 3, 0, COL_BLACK, 0));
				send_command(make_cmd(ACT_HSPAN, 5, 5, 3, 0, COL_INVERT, 0));
				send_command(make_cmd(ACT_HSPAN, 0, SCREEN_WIDTH - 1, 3, 0, COL_HATCH2, 0));
				send_command(make_cmd(ACT_HSPAN, SCREEN_WIDTH - 1, 0, SCREEN_HEIGHT - 1, 0,
					COL_HATCH1, 0));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 1));
				// Column spans: one byte inverted, several pages, zero length, empty pattern, a hatch, an undefined colour.
				send_command(make_cmd(ACT_VSPAN, 20, 0, 5, 2, COL_INVERT, 0));
				send_command(make_cmd(ACT_VSPAN, 21, 0, 45, 1, COL_BLACK, 0));
				send_command(make_cmd(ACT_VSPAN, 21, 0, 7, 7, COL_WHITE, 0));
				send_command(make_cmd(ACT_VSPAN, 22, 0, 0, SCREEN_HEIGHT - 1, COL_HATCH1, 0));
				send_command(make_cmd(ACT_VSPAN, 23, 0, 3, 30, COL_HATCH3, 0));
				send_command(make_cmd(ACT_VSPAN, 24, 0, 0, SCREEN_HEIGHT - 1, 3'd7, 0));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 20));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 3 * SCREEN_WIDTH + 23));
				// Whole-buffer fills, then an undefined command.
				send_command(make_cmd(ACT_FILL, 0, 0, 0, 0, COL_HATCH1, 0));
				send_command(make_cmd(ACT_FILL, 0, 0, 0, 0, COL_INVERT, 0));
				send_command(make_cmd(ACT_FILL, 0, 0, 0, 0, 3'd6, 0));
				send_command(make_cmd(3'd7, 0, 0, 0, 0, COL_BLACK, 0));
				send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE, 300));

				// Receiver holds off while reads keep coming, so the output backs up.
				hold_left = 400;
				repeat (40)
					send_command(make_cmd(ACT_READ, 0, 0, 0, 0, COL_WHITE,
						$urandom_range(STORE_BYTES - 1)));
			end

			repeat (96) send_command(random_command());
		end

		in_valid = 1'b0;
		settle_engine();
		sb.check_drained();
		if (sb.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== mono_framebuffer_span_engine_top.f =====
+incdir+hdl
hdl/fbse_pkg.sv
hdl/fbse_ram.sv
hdl/fbse_engine.sv
hdl/mono_framebuffer_span_engine_top.sv
tb/sv/tb_mono_framebuffer_span_engine_top.sv
